### rtl/cpas_pkg.sv
// Shared types, codes and the resource classification of the pipeline admission scoreboard.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package cpas_pkg;

    localparam int SRC_W      = 3;
    localparam int RES_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // request sources
    localparam logic [SRC_W-1:0] SRC_L2_MISS    = 3'd0;
    localparam logic [SRC_W-1:0] SRC_L2_WB      = 3'd1;
    localparam logic [SRC_W-1:0] SRC_SNOOP      = 3'd2;
    localparam logic [SRC_W-1:0] SRC_L3_GRANT   = 3'd3;
    localparam logic [SRC_W-1:0] SRC_L3_RELEASE = 3'd4;
    localparam logic [SRC_W-1:0] SRC_PREFETCH   = 3'd5;

    // stage source code: zero is empty, otherwise source plus one
    localparam logic [SRC_W-1:0] CODE_EMPTY    = 3'd0;
    localparam logic [SRC_W-1:0] CODE_L3_GRANT = SRC_L3_GRANT + 3'd1;

    // resource bits
    localparam logic [RES_W-1:0] RES_NONE   = 5'b00000;
    localparam logic [RES_W-1:0] RES_DIR_RD = 5'b00001;
    localparam logic [RES_W-1:0] RES_DIR_WR = 5'b00010;
    localparam logic [RES_W-1:0] RES_DAT_RD = 5'b00100;
    localparam logic [RES_W-1:0] RES_DAT_WR = 5'b01000;
    localparam logic [RES_W-1:0] RES_GRANT  = 5'b10000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_WRITE_STAGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_READ_BYPASS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_SHIFT      = 2'd2;

    localparam logic [4:0] RST_DIR_WRITE_STAGE = 5'd3;
    localparam logic       RST_DIR_READ_BYPASS = 1'b0;
    localparam logic [4:0] RST_LINE_SHIFT      = 5'd6;

    typedef struct packed {
        logic [4:0] dir_write_stage;
        logic       dir_read_bypass;
        logic [4:0] line_shift;
    } cfg_t;

    typedef struct packed {
        logic accepted;
        logic set_conflict;
        logic data_bank_stall;
        logic dir_bank_stall;
    } admit_t;

    function automatic logic [RES_W-1:0] needs_of(
        input logic [SRC_W-1:0] src,
        input logic             hit,
        input logic             upg
    );
        logic [RES_W-1:0] r;
        case (src)
            SRC_L2_MISS: begin
                r = RES_DIR_RD;
                if (hit) begin
                    r = r | RES_DIR_WR;
                    if (!upg) begin
                        r = r | RES_DAT_RD;
                    end
                end
            end
            SRC_L2_WB:      r = RES_DIR_RD | RES_DIR_WR | RES_DAT_WR | RES_GRANT;
            SRC_SNOOP: begin
                r = RES_DIR_RD;
                if (hit) begin
                    r = r | RES_DIR_WR | RES_DAT_RD;
                end
            end
            SRC_L3_GRANT:   r = RES_DIR_RD | RES_DAT_RD | RES_GRANT;
            SRC_L3_RELEASE: r = RES_DAT_WR;
            SRC_PREFETCH:   r = RES_DIR_RD;
            default:        r = RES_NONE;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/cpas_cfg.sv
// Configuration register file: directory write stage, read bypass and line shift.
// Depends on cpas_pkg.
`default_nettype none

module cpas_cfg (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [cpas_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [cpas_pkg::CFG_DATA_W-1:0] cfg_data,
    output cpas_pkg::cfg_t                  cfg
);
    import cpas_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dir_write_stage <= RST_DIR_WRITE_STAGE;
            cfg_reg.dir_read_bypass <= RST_DIR_READ_BYPASS;
            cfg_reg.line_shift      <= RST_LINE_SHIFT;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DIR_WRITE_STAGE: cfg_reg.dir_write_stage <= cfg_data;
                CFG_DIR_READ_BYPASS: cfg_reg.dir_read_bypass <= cfg_data[0];
                CFG_LINE_SHIFT:      cfg_reg.line_shift      <= cfg_data;
                default:             cfg_reg <= cfg_reg; // drop writes past the list
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/cpas_admit.sv
// Admission check: classifies a request and tests set, data bank and directory bank
// conflicts against the scoreboard stages. Depends on cpas_pkg.
`default_nettype none

module cpas_admit #(
    parameter int DEPTH          = 6,
    parameter int ADDR_BITS      = 48,
    parameter int SET_BITS       = 10,
    parameter int DATA_BANK_BITS = 2,
    parameter int DIR_BANK_BITS  = 2
) (
    input  cpas_pkg::cfg_t                               cfg,
    input  wire                                          req_valid,
    input  wire  [cpas_pkg::SRC_W-1:0]                   source,
    input  wire  [ADDR_BITS-1:0]                         addr,
    input  wire                                          hit,
    input  wire                                          is_upgrade,
    input  wire  [DEPTH-1:0][cpas_pkg::SRC_W-1:0]        st_src,
    input  wire  [DEPTH-1:0][cpas_pkg::RES_W-1:0]        st_res,
    input  wire  [DEPTH-1:0][ADDR_BITS-1:0]              st_addr,
    output cpas_pkg::admit_t                             admit,
    output logic [cpas_pkg::RES_W-1:0]                   need
);
    import cpas_pkg::*;

    localparam logic [SET_BITS-1:0] DATA_MASK =
        SET_BITS'((64'd1 << DATA_BANK_BITS) - 64'd1);
    localparam logic [SET_BITS-1:0] DIR_MASK =
        SET_BITS'((64'd1 << DIR_BANK_BITS) - 64'd1);

    function automatic logic [SET_BITS-1:0] set_of(
        input logic [ADDR_BITS-1:0] a,
        input logic [4:0]           sh
    );
        return SET_BITS'(a >> sh);
    endfunction

    logic [SET_BITS-1:0] set_in;
    logic [DEPTH-1:0]    set_eq;
    logic [DEPTH-1:0]    dir_eq;
    logic [DEPTH-1:0]    at_ws;
    logic [DEPTH-1:0]    scan_sel;
    logic                data_eq1;
    logic [4:0]          ws;
    logic                ws_ok;
    logic                req_ok;
    logic                l2_miss;
    logic                block;
    logic                drop_rd;
    logic [RES_W-1:0]    eff;
    logic                dstall;
    logic                rstall;

    assign ws      = cfg.dir_write_stage - 5'd1;
    assign ws_ok   = (cfg.dir_write_stage != 5'd0) && (cfg.dir_write_stage <= 5'(DEPTH));
    assign req_ok  = req_valid && (source <= SRC_PREFETCH);
    assign l2_miss = (source == SRC_L2_MISS);
    assign set_in  = set_of(addr, cfg.line_shift);
    assign need    = needs_of(source, hit, is_upgrade);

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            set_eq[i]   = (set_in == set_of(st_addr[i], cfg.line_shift));
            dir_eq[i]   = ((set_in ^ set_of(st_addr[i], cfg.line_shift)) & DIR_MASK) == '0;
            at_ws[i]    = ws_ok && (ws == 5'(i));
            // set blocking covers stages 1 up to the write stage, or all when none is named or it is out of range
            scan_sel[i] = (i != 0) && (!ws_ok || (5'(i) <= ws));
        end
    end

    assign data_eq1 = ((set_in ^ set_of(st_addr[1], cfg.line_shift)) & DATA_MASK) == '0;

    always_comb begin
        block = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            if (scan_sel[i] && (st_src[i] != CODE_EMPTY) && set_eq[i]) begin
                block = 1'b1;
            end
        end
        block   = block && l2_miss && !cfg.dir_read_bypass;
        drop_rd = cfg.dir_read_bypass && l2_miss && ((at_ws & set_eq) != '0);
        eff     = drop_rd ? (need & ~RES_DIR_RD) : need;
        dstall  = ((eff & (RES_DAT_RD | RES_DAT_WR)) != RES_NONE) &&
                  ((st_res[1] & (RES_DAT_RD | RES_DAT_WR)) != RES_NONE) && data_eq1;
        rstall  = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            if (at_ws[i] && ((st_res[i] & RES_DIR_WR) != RES_NONE) && dir_eq[i]) begin
                rstall = 1'b1;
            end
        end
        rstall = rstall && ((eff & RES_DIR_RD) != RES_NONE);
    end

    assign admit.accepted        = req_ok && !block && !dstall && !rstall;
    assign admit.set_conflict    = req_ok && l2_miss && block;
    assign admit.data_bank_stall = req_ok && l2_miss && dstall;
    assign admit.dir_bank_stall  = req_ok && l2_miss && rstall;

endmodule

`default_nettype wire

### rtl/cpas_board.sv
// Scoreboard stage registers: grant release of the oldest pending grant and the
// one-stage shift per item. Depends on cpas_pkg.
`default_nettype none

module cpas_board #(
    parameter int DEPTH     = 6,
    parameter int ADDR_BITS = 48,
    parameter int TAG_BITS  = 8
) (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    input  wire                                    advance,
    input  wire                                    accepted,
    input  wire  [cpas_pkg::SRC_W-1:0]             source,
    input  wire  [cpas_pkg::RES_W-1:0]             need,
    input  wire  [ADDR_BITS-1:0]                   addr,
    input  wire  [TAG_BITS-1:0]                    tag,
    output logic [DEPTH-1:0][cpas_pkg::SRC_W-1:0]  st_src,
    output logic [DEPTH-1:0][cpas_pkg::RES_W-1:0]  st_res,
    output logic [DEPTH-1:0][ADDR_BITS-1:0]        st_addr,
    output logic                                   grant_valid,
    output logic [TAG_BITS-1:0]                    grant_tag,
    output logic                                   busy_res
);
    import cpas_pkg::*;

    logic [SRC_W-1:0]     src_reg  [1:DEPTH-1];
    logic [RES_W-1:0]     res_reg  [1:DEPTH-1];
    logic [ADDR_BITS-1:0] addr_reg [1:DEPTH-1];
    logic [TAG_BITS-1:0]  tag_reg  [1:DEPTH-1];
    logic [DEPTH-1:0]     grant_sel;

    // stage 0 is always empty between items
    always_comb begin
        st_src[0]  = CODE_EMPTY;
        st_res[0]  = RES_NONE;
        st_addr[0] = '0;
        for (int i = 1; i < DEPTH; i++) begin
            st_src[i]  = src_reg[i];
            st_res[i]  = res_reg[i];
            st_addr[i] = addr_reg[i];
        end
    end

    // oldest stage from index 2 up holding an unreleased grant
    always_comb begin
        grant_valid = 1'b0;
        grant_tag   = '0;
        grant_sel   = '0;
        for (int i = DEPTH - 1; i >= 2; i--) begin
            if (!grant_valid && (src_reg[i] == CODE_L3_GRANT) &&
                ((res_reg[i] & RES_GRANT) != RES_NONE)) begin
                grant_valid  = 1'b1;
                grant_tag    = tag_reg[i];
                grant_sel[i] = 1'b1;
            end
        end
    end

    always_comb begin
        busy_res = accepted;
        for (int i = 1; i < DEPTH - 1; i++) begin
            if (src_reg[i] != CODE_EMPTY) begin
                busy_res = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i < DEPTH; i++) begin
                src_reg[i]  <= CODE_EMPTY;
                res_reg[i]  <= RES_NONE;
                addr_reg[i] <= '0;
                tag_reg[i]  <= '0;
            end
        end else if (advance) begin
            src_reg[1]  <= accepted ? (source + 3'd1) : CODE_EMPTY;
            res_reg[1]  <= accepted ? need : RES_NONE;
            addr_reg[1] <= accepted ? addr : '0;
            tag_reg[1]  <= accepted ? tag : '0;
            for (int i = 2; i < DEPTH; i++) begin
                src_reg[i]  <= src_reg[i-1];
                res_reg[i]  <= grant_sel[i-1] ? (res_reg[i-1] & ~RES_GRANT) : res_reg[i-1];
                addr_reg[i] <= addr_reg[i-1];
                tag_reg[i]  <= tag_reg[i-1];
            end
        end
    end

endmodule

`default_nettype wire

### rtl/cache_pipe_admission_scoreboard.sv
// Top level of the cache pipeline admission scoreboard: input register, admission
// check, stage scoreboard and result register. Depends on cpas_pkg, cpas_cfg,
// cpas_admit and cpas_board.
//
// Usage:
//   Each s_ transaction is one tick of the main pipeline, with or without a
//   request (s_req_valid). Each produces exactly one m_ transaction carrying the
//   admission verdict, the conflict flags, any grant released on that tick and
//   whether the pipeline is still occupied after the shift.
//   From s_ acceptance to m_valid a transaction passes the input register, then
//   the result register; throughput is one transaction per cycle while the
//   receiver keeps m_ready high, set by the single pass through the admission
//   check and the stage shift.
//   The cfg_ channel is always ready; write it only while no transaction is in
//   flight. Index 0 dir_write_stage, 1 dir_read_bypass, 2 line_shift; other
//   indexes are dropped.
//   Reset (aresetn low, synchronous) empties every stage, restores the register
//   defaults (3, 0, 6) and clears both valid flags.
//   When the receiver stalls, the result register holds, the input register
//   holds one further transaction, and s_ready falls until m_ready returns.
`default_nettype none

module cache_pipe_admission_scoreboard #(
    parameter int DEPTH          = 6,
    parameter int ADDR_BITS      = 48,
    parameter int TAG_BITS       = 8,
    parameter int SET_BITS       = 10,
    parameter int DATA_BANK_BITS = 2,
    parameter int DIR_BANK_BITS  = 2
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    // request channel
    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire                             s_req_valid,
    input  wire  [cpas_pkg::SRC_W-1:0]      s_source,
    input  wire  [ADDR_BITS-1:0]            s_addr,
    input  wire                             s_hit,
    input  wire                             s_is_upgrade,
    input  wire  [TAG_BITS-1:0]             s_tag,
    // result channel
    output logic                            m_valid,
    input  wire                             m_ready,
    output logic                            m_accepted,
    output logic                            m_set_conflict,
    output logic                            m_data_bank_stall,
    output logic                            m_dir_bank_stall,
    output logic                            m_grant_valid,
    output logic [TAG_BITS-1:0]             m_grant_tag,
    output logic                            m_busy_res,
    // configuration channel
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [cpas_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [cpas_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cpas_pkg::*;

    // input register
    logic                 in_valid_reg;
    logic                 req_valid_reg;
    logic [SRC_W-1:0]     source_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic                 hit_reg;
    logic                 upgrade_reg;
    logic [TAG_BITS-1:0]  tag_reg;

    // result register
    logic                 out_valid_reg;
    admit_t               admit_reg;
    logic                 grant_valid_reg;
    logic [TAG_BITS-1:0]  grant_tag_reg;
    logic                 busy_reg;

    cfg_t                             cfg;
    admit_t                           admit;
    logic [RES_W-1:0]                 need;
    logic [DEPTH-1:0][SRC_W-1:0]      st_src;
    logic [DEPTH-1:0][RES_W-1:0]      st_res;
    logic [DEPTH-1:0][ADDR_BITS-1:0]  st_addr;
    logic                             grant_valid;
    logic [TAG_BITS-1:0]              grant_tag;
    logic                             busy_res;
    logic                             advance;
    logic                             in_take;

    // advance the scoreboard whenever a held transaction has somewhere to go
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_take = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            req_valid_reg <= s_req_valid;
            source_reg    <= s_source;
            addr_reg      <= s_addr;
            hit_reg       <= s_hit;
            upgrade_reg   <= s_is_upgrade;
            tag_reg       <= s_tag;
        end
    end

    cpas_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cpas_admit #(
        .DEPTH          (DEPTH),
        .ADDR_BITS      (ADDR_BITS),
        .SET_BITS       (SET_BITS),
        .DATA_BANK_BITS (DATA_BANK_BITS),
        .DIR_BANK_BITS  (DIR_BANK_BITS)
    ) u_admit (
        .cfg        (cfg),
        .req_valid  (req_valid_reg),
        .source     (source_reg),
        .addr       (addr_reg),
        .hit        (hit_reg),
        .is_upgrade (upgrade_reg),
        .st_src     (st_src),
        .st_res     (st_res),
        .st_addr    (st_addr),
        .admit      (admit),
        .need       (need)
    );

    cpas_board #(
        .DEPTH     (DEPTH),
        .ADDR_BITS (ADDR_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_board (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .accepted    (admit.accepted),
        .source      (source_reg),
        .need        (need),
        .addr        (addr_reg),
        .tag         (tag_reg),
        .st_src      (st_src),
        .st_res      (st_res),
        .st_addr     (st_addr),
        .grant_valid (grant_valid),
        .grant_tag   (grant_tag),
        .busy_res    (busy_res)
    );

    // hold the result until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            admit_reg       <= admit;
            grant_valid_reg <= grant_valid;
            grant_tag_reg   <= grant_tag;
            busy_reg        <= busy_res;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_accepted        = admit_reg.accepted;
    assign m_set_conflict    = admit_reg.set_conflict;
    assign m_data_bank_stall = admit_reg.data_bank_stall;
    assign m_dir_bank_stall  = admit_reg.dir_bank_stall;
    assign m_grant_valid     = grant_valid_reg;
    assign m_grant_tag       = grant_tag_reg;
    assign m_busy_res        = busy_reg;

    // a reported conflict always means the request was refused
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_set_conflict || m_data_bank_stall || m_dir_bank_stall) |-> !m_accepted)
        else $error("conflict flag raised on an admitted request");

    // an admitted request occupies stage 1 after the shift
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |-> m_busy_res)
        else $error("admitted request but pipeline reported empty");

    // no grant, no tag
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_grant_valid |-> (m_grant_tag == '0))
        else $error("grant tag set without a released grant");

    // every scoreboard step produces a result on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("scoreboard advanced without a result");

endmodule

`default_nettype wire

### tb/sv/cpas_check_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the cache pipeline admission block: a tick-by-tick model of the
// stage board and the queue of verdicts still due. Depends on cpas_pkg.
package cpas_check_pkg;
    import cpas_pkg::*;

    localparam int DEPTH          = 6;
    localparam int ADDR_BITS      = 48;
    localparam int TAG_BITS       = 8;
    localparam int SET_BITS       = 10;
    localparam int DATA_BANK_BITS = 2;
    localparam int DIR_BANK_BITS  = 2;

    // index past the register list; the block must drop writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic                 req_valid;
        logic [SRC_W-1:0]     source;
        logic [ADDR_BITS-1:0] addr;
        logic                 hit;
        logic                 is_upgrade;
        logic [TAG_BITS-1:0]  tag;
    } tick_t;

    typedef struct packed {
        logic                accepted;
        logic                set_conflict;
        logic                data_bank_stall;
        logic                dir_bank_stall;
        logic                grant_valid;
        logic [TAG_BITS-1:0] grant_tag;
        logic                busy_res;
    } verdict_t;

    class admission_scoreboard;
        cfg_t                 cfg;
        logic [SRC_W-1:0]     code  [DEPTH];
        logic [RES_W-1:0]     held  [DEPTH];
        logic [ADDR_BITS-1:0] where [DEPTH];
        logic [TAG_BITS-1:0]  ident [DEPTH];
        verdict_t             verdicts_due[$];
        int                   errors;

        function new();
            int i;
            cfg.dir_write_stage = RST_DIR_WRITE_STAGE;
            cfg.dir_read_bypass = RST_DIR_READ_BYPASS;
            cfg.line_shift      = RST_LINE_SHIFT;
            for (i = 0; i < DEPTH; i++) begin
                code[i]  = CODE_EMPTY;
                held[i]  = RES_NONE;
                where[i] = '0;
                ident[i] = '0;
            end
            errors = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DIR_WRITE_STAGE: cfg.dir_write_stage = data;
                CFG_DIR_READ_BYPASS: cfg.dir_read_bypass = data[0];
                CFG_LINE_SHIFT:      cfg.line_shift      = data;
                default: ;
            endcase
        endfunction

        function logic [SET_BITS-1:0] set_of(logic [ADDR_BITS-1:0] a);
            logic [ADDR_BITS-1:0] s;
            s = a >> cfg.line_shift;
            return s[SET_BITS-1:0];
        endfunction

        function logic [RES_W-1:0] demand(logic [SRC_W-1:0] src, logic hit, logic upg);
            logic [RES_W-1:0] r;
            case (src)
                SRC_L2_MISS, SRC_SNOOP, SRC_PREFETCH: r = RES_DIR_RD;
                SRC_L2_WB:      r = RES_DIR_RD | RES_DIR_WR | RES_DAT_WR | RES_GRANT;
                SRC_L3_GRANT:   r = RES_DIR_RD | RES_DAT_RD | RES_GRANT;
                SRC_L3_RELEASE: r = RES_DAT_WR;
                default:        r = RES_NONE;
            endcase
            if (hit && src == SRC_L2_MISS)
                r = r | (upg ? RES_DIR_WR : (RES_DIR_WR | RES_DAT_RD));
            if (hit && src == SRC_SNOOP)
                r = r | RES_DIR_WR | RES_DAT_RD;
            return r;
        endfunction

        // advance the board by one tick and queue the verdict it yields
        function void note_tick(tick_t t);
            verdict_t             v;
            logic [RES_W-1:0]     need;
            logic [RES_W-1:0]     eff;
            logic [SET_BITS-1:0]  own_set;
            logic [SET_BITS-1:0]  other;
            logic                 blocked;
            logic                 dstall;
            logic                 rstall;
            logic                 released;
            int                   ws;
            int                   top;
            int                   i;

            v       = '0;
            ws      = (cfg.dir_write_stage == 0) ? DEPTH : int'(cfg.dir_write_stage) - 1;
            own_set = set_of(t.addr);
            if (t.req_valid && t.source <= SRC_PREFETCH) begin
                need    = demand(t.source, t.hit, t.is_upgrade);
                eff     = need;
                blocked = 1'b0;
                top     = (ws < DEPTH - 1) ? ws : DEPTH - 1;
                if (t.source == SRC_L2_MISS) begin
                    for (i = 1; i <= top; i++)
                        if (code[i] != CODE_EMPTY && set_of(where[i]) == own_set)
                            blocked = 1'b1;
                end
                if (cfg.dir_read_bypass) begin
                    if (ws < DEPTH && t.source == SRC_L2_MISS) begin
                        if (set_of(where[ws]) == own_set)
                            eff = eff & ~RES_DIR_RD;
                    end
                    blocked = 1'b0;
                end
                other  = set_of(where[1]);
                dstall = (eff & (RES_DAT_RD | RES_DAT_WR)) != RES_NONE &&
                         (held[1] & (RES_DAT_RD | RES_DAT_WR)) != RES_NONE &&
                         other[DATA_BANK_BITS-1:0] == own_set[DATA_BANK_BITS-1:0];
                rstall = 1'b0;
                if (ws < DEPTH) begin
                    other  = set_of(where[ws]);
                    rstall = (eff & RES_DIR_RD) != RES_NONE &&
                             (held[ws] & RES_DIR_WR) != RES_NONE &&
                             other[DIR_BANK_BITS-1:0] == own_set[DIR_BANK_BITS-1:0];
                end
                v.accepted = code[0] == CODE_EMPTY && !blocked && !dstall && !rstall;
                if (v.accepted) begin
                    code[0]  = t.source + 3'd1;
                    held[0]  = held[0] | need;
                    where[0] = t.addr;
                    ident[0] = t.tag;
                end
                if (t.source == SRC_L2_MISS) begin
                    v.set_conflict    = blocked;
                    v.data_bank_stall = dstall;
                    v.dir_bank_stall  = rstall;
                end
            end

            released = 1'b0;
            for (i = DEPTH - 1; i >= 2; i--) begin
                if (!released && code[i] == CODE_L3_GRANT && (held[i] & RES_GRANT) != RES_NONE) begin
                    released      = 1'b1;
                    v.grant_valid = 1'b1;
                    v.grant_tag   = ident[i];
                    held[i]       = held[i] & ~RES_GRANT;
                end
            end

            for (i = DEPTH - 1; i >= 1; i--) begin
                code[i]  = code[i-1];
                held[i]  = held[i-1];
                where[i] = where[i-1];
                ident[i] = ident[i-1];
            end
            code[0]  = CODE_EMPTY;
            held[0]  = RES_NONE;
            where[0] = '0;
            ident[0] = '0;
            for (i = 0; i < DEPTH; i++)
                if (code[i] != CODE_EMPTY)
                    v.busy_res = 1'b1;

            verdicts_due.push_back(v);
        endfunction

        function void match_field(string name, logic [TAG_BITS-1:0] want, logic [TAG_BITS-1:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_verdict(verdict_t got);
            verdict_t want;
            if (verdicts_due.size() == 0) begin
                errors++;
                $display("%0t: verdict expected none, got %0h", $time, got);
                return;
            end
            want = verdicts_due.pop_front();
            match_field("accepted",        TAG_BITS'(want.accepted),
                        TAG_BITS'(got.accepted));
            match_field("set_conflict",    TAG_BITS'(want.set_conflict),
                        TAG_BITS'(got.set_conflict));
            match_field("data_bank_stall", TAG_BITS'(want.data_bank_stall),
                        TAG_BITS'(got.data_bank_stall));
            match_field("dir_bank_stall",  TAG_BITS'(want.dir_bank_stall),
                        TAG_BITS'(got.dir_bank_stall));
            match_field("grant_valid",     TAG_BITS'(want.grant_valid),
                        TAG_BITS'(got.grant_valid));
            match_field("grant_tag",       want.grant_tag,       got.grant_tag);
            match_field("busy_res",        TAG_BITS'(want.busy_res),
                        TAG_BITS'(got.busy_res));
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

endpackage

### tb/sv/cache_pipe_admission_scoreboard_test.sv
`timescale 1ns / 100ps
// Self-checking bench for cache_pipe_admission_scoreboard: directed and random
// pipeline ticks under several register settings. Depends on cpas_pkg, cpas_check_pkg.
module cache_pipe_admission_scoreboard_test;
    import cpas_pkg::*;
    import cpas_check_pkg::*;

    localparam int WATCHDOG_LIMIT  = 1000;   // cycles with no transaction at all
    localparam int SETTLE_CYCLES   = 6;      // well past the block latency
    localparam int PHASES          = 9;
    localparam int TICKS_PER_PHASE = 58;     // ticks carrying a real request

    // register plan per phase; phase 0 runs on the reset values
    localparam logic [4:0] STAGE_PLAN  [PHASES] = '{5'd3, 5'd1, 5'd16, 5'd0, 5'd2,
                                                   5'd7, 5'd31, 5'd4, 5'd6};
    localparam logic       BYPASS_PLAN [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
                                                   1'b1, 1'b0, 1'b1, 1'b0};
    localparam logic [4:0] SHIFT_PLAN  [PHASES] = '{5'd6, 5'd0, 5'd20, 5'd6, 5'd31,
                                                   5'd6, 5'd13, 5'd6, 5'd6};

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_req_valid   = 1'b0;
    logic [SRC_W-1:0]      s_source      = SRC_L2_MISS;
    logic [ADDR_BITS-1:0]  s_addr        = '0;
    logic                  s_hit         = 1'b0;
    logic                  s_is_upgrade  = 1'b0;
    logic [TAG_BITS-1:0]   s_tag         = '0;
    logic                  m_ready       = 1'b1;
    logic                  cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = CFG_DIR_WRITE_STAGE;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    logic                  s_ready;
    logic                  m_valid;
    logic                  m_accepted;
    logic                  m_set_conflict;
    logic                  m_data_bank_stall;
    logic                  m_dir_bank_stall;
    logic                  m_grant_valid;
    logic [TAG_BITS-1:0]   m_grant_tag;
    logic                  m_busy_res;
    logic                  cfg_ready;

    verdict_t              seen;
    admission_scoreboard   board;
    logic [SET_BITS-1:0]   hot [4];
    bit                    idle_on    = 1'b0;
    bit                    stall_on   = 1'b0;
    bit                    tail_quiet = 1'b0;
    int                    stall_left = 0;
    int unsigned           quiet_cycles = 0;

    cache_pipe_admission_scoreboard i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_valid       (s_req_valid),
        .s_source          (s_source),
        .s_addr            (s_addr),
        .s_hit             (s_hit),
        .s_is_upgrade      (s_is_upgrade),
        .s_tag             (s_tag),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_accepted        (m_accepted),
        .m_set_conflict    (m_set_conflict),
        .m_data_bank_stall (m_data_bank_stall),
        .m_dir_bank_stall  (m_dir_bank_stall),
        .m_grant_valid     (m_grant_valid),
        .m_grant_tag       (m_grant_tag),
        .m_busy_res        (m_busy_res),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    assign seen = {m_accepted, m_set_conflict, m_data_bank_stall, m_dir_bank_stall,
                   m_grant_valid, m_grant_tag, m_busy_res};

    // Result side: at random, hold m_ready low for a burst while stalling is
    // enabled for the phase; keep it high throughout the quiet tail of the run.
    always @(posedge aclk) begin
        if (!stall_on || tail_quiet) begin
            m_ready <= 1'b1;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Check every result transaction against the oldest due verdict, and end the
    // run if the block goes silent on all three channels for too long.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_verdict(seen);
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic tick_t mk(logic req, logic [SRC_W-1:0] src, logic [ADDR_BITS-1:0] a,
                                 logic hit, logic upg, logic [TAG_BITS-1:0] tag);
        tick_t t;
        t.req_valid  = req;
        t.source     = src;
        t.addr       = a;
        t.hit        = hit;
        t.is_upgrade = upg;
        t.tag        = tag;
        return t;
    endfunction

    // Random address whose set index, at the current line shift, is the given set.
    function automatic logic [ADDR_BITS-1:0] place(logic [SET_BITS-1:0] set_idx);
        logic [63:0]          r;
        logic [ADDR_BITS-1:0] field;
        r     = {$urandom, $urandom};
        field = {{(ADDR_BITS-SET_BITS){1'b0}}, {SET_BITS{1'b1}}} << board.cfg.line_shift;
        return (r[ADDR_BITS-1:0] & ~field) |
               ({{(ADDR_BITS-SET_BITS){1'b0}}, set_idx} << board.cfg.line_shift);
    endfunction

    // Mostly requests aimed at a few hot sets, so that same-set and same-bank
    // conflicts come up often; the rest are spread over the whole address space.
    function automatic tick_t random_tick();
        tick_t       t;
        int          pick;
        logic [63:0] r;
        pick        = $urandom_range(0, 99);
        t.req_valid = $urandom_range(0, 9) != 0;
        if (pick < 40)      t.source = SRC_L2_MISS;
        else if (pick < 50) t.source = SRC_L2_WB;
        else if (pick < 60) t.source = SRC_SNOOP;
        else if (pick < 72) t.source = SRC_L3_GRANT;
        else if (pick < 82) t.source = SRC_L3_RELEASE;
        else if (pick < 92) t.source = SRC_PREFETCH;
        else                t.source = SRC_PREFETCH + 3'($urandom_range(1, 2));
        t.hit        = 1'($urandom_range(0, 1));
        t.is_upgrade = 1'($urandom_range(0, 1));
        t.tag        = TAG_BITS'($urandom);
        if ($urandom_range(0, 6) == 0) begin
            r      = {$urandom, $urandom};
            t.addr = r[ADDR_BITS-1:0];
        end else begin
            t.addr = place(hot[$urandom_range(0, 3)]);
        end
        return t;
    endfunction

    // Offer one tick, hold it until taken, then advance the model with it.
    task automatic send_tick(input tick_t t);
        s_valid      <= 1'b1;
        s_req_valid  <= t.req_valid;
        s_source     <= t.source;
        s_addr       <= t.addr;
        s_hit        <= t.hit;
        s_is_upgrade <= t.is_upgrade;
        s_tag        <= t.tag;
        do @(posedge aclk); while (!s_ready);
        board.note_tick(t);
    endtask

    // Drop valid and wait for every due verdict, then let the pipe settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all three registers back to back; optionally also poke the unmapped
    // index, which the block must ignore. Only called with the pipe drained.
    task automatic program_regs(input logic [4:0] stage, input logic bypass,
                                input logic [4:0] shift, input bit poke);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        int                    n;
        int                    i;
        idx[0] = CFG_UNMAPPED;        val[0] = CFG_DATA_W'($urandom);
        idx[1] = CFG_DIR_WRITE_STAGE; val[1] = stage;
        idx[2] = CFG_DIR_READ_BYPASS; val[2] = {4'($urandom_range(0, 15)), bypass};
        idx[3] = CFG_LINE_SHIFT;      val[3] = shift;
        n = poke ? 0 : 1;
        for (i = n; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
            board.set_register(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int    p;
        int    useful;
        tick_t t;

        board = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed ticks on the reset settings (write stage index 2, no bypass,
        // line shift 6): an empty tick, address extremes, each conflict kind,
        // every source including the two unknown codes, and grant release.
        send_tick(mk(1'b0, SRC_L2_MISS,    48'h0,              1'b0, 1'b0, 8'h00));
        send_tick(mk(1'b1, SRC_L2_MISS,    48'h0,              1'b0, 1'b0, 8'h00));
        send_tick(mk(1'b1, SRC_L2_MISS,    48'h0000_0000_0010, 1'b1, 1'b0, 8'h01));
        send_tick(mk(1'b1, SRC_L3_RELEASE, 48'hffff_ffff_ffff, 1'b0, 1'b0, 8'hff));
        send_tick(mk(1'b1, SRC_L2_MISS,    48'h0000_0000_3fc0, 1'b1, 1'b0, 8'h02));
        send_tick(mk(1'b1, SRC_L2_WB,      48'h0000_0000_1240, 1'b0, 1'b0, 8'h5a));
        send_tick(mk(1'b0, SRC_L2_MISS,    48'h0,              1'b0, 1'b0, 8'h00));
        send_tick(mk(1'b1, SRC_L2_MISS,    48'h0000_0000_0140, 1'b1, 1'b1, 8'h03));
        send_tick(mk(1'b1, SRC_L3_GRANT,   48'h0abc_def0_1234, 1'b1, 1'b1, 8'ha5));
        send_tick(mk(1'b1, SRC_L3_GRANT,   48'h8000_0000_0040, 1'b0, 1'b0, 8'h3c));
        send_tick(mk(1'b1, SRC_SNOOP,      48'h5555_5555_5555, 1'b1, 1'b0, 8'h55));
        send_tick(mk(1'b1, SRC_SNOOP,      48'haaaa_aaaa_aaaa, 1'b0, 1'b0, 8'haa));
        send_tick(mk(1'b1, SRC_PREFETCH,   48'h0000_0000_0080, 1'b1, 1'b1, 8'h10));
        send_tick(mk(1'b1, SRC_PREFETCH + 3'd1, 48'h0,         1'b1, 1'b0, 8'h20));
        send_tick(mk(1'b1, SRC_PREFETCH + 3'd2, 48'hffff_ffff_ffff, 1'b0, 1'b1, 8'h40));
        send_tick(mk(1'b0, SRC_L3_GRANT,   48'h0,              1'b0, 1'b0, 8'h00));
        send_tick(mk(1'b0, SRC_L2_MISS,    48'h0,              1'b0, 1'b0, 8'h00));
        send_tick(mk(1'b1, SRC_L3_GRANT,   48'h0000_0000_0040, 1'b0, 1'b0, 8'h81));
        send_tick(mk(1'b1, SRC_L3_GRANT,   48'h0000_0000_0080, 1'b0, 1'b0, 8'h82));
        send_tick(mk(1'b1, SRC_L2_MISS,    48'hffff_ffff_ffff, 1'b1, 1'b0, 8'hff));
        send_tick(mk(1'b0, SRC_L2_MISS,    48'h0,              1'b0, 1'b0, 8'h00));

        for (p = 0; p < PHASES; p++) begin
            // Drain before each register change; the first phase keeps reset values.
            if (p != 0) begin
                drain();
                program_regs(STAGE_PLAN[p], BYPASS_PLAN[p], SHIFT_PLAN[p], p == 1);
            end
            tail_quiet = (p == PHASES - 1);
            idle_on    = $urandom_range(0, 3) != 0;
            stall_on   = $urandom_range(0, 3) != 0;
            hot[0]     = SET_BITS'($urandom);
            hot[1]     = hot[0] ^ 10'h3f0;   // different set, same banks
            hot[2]     = SET_BITS'($urandom);
            hot[3]     = hot[2] + 10'd1;

            useful = 0;
            while (useful < TICKS_PER_PHASE) begin
                // Hold the sender off until the pipe is empty once per odd phase.
                if (p % 2 == 1 && useful == TICKS_PER_PHASE / 2)
                    drain();
                if (idle_on && !tail_quiet && $urandom_range(0, 6) == 0) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge aclk);
                end
                t = random_tick();
                send_tick(t);
                if (t.req_valid && t.source <= SRC_PREFETCH)
                    useful++;
            end
        end

        drain();
        if (board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
rtl/cpas_pkg.sv
rtl/cpas_cfg.sv
rtl/cpas_admit.sv
rtl/cpas_board.sv
rtl/cache_pipe_admission_scoreboard.sv
tb/sv/cpas_check_pkg.sv
tb/sv/cache_pipe_admission_scoreboard_test.sv
